// File: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the button press classifier
// Event codes, register indexes, reset values and the front-to-back entry.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // Register file
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HOLD_INTERVAL    = 2'd0,
      CSR_LONG_PRESS_TICKS = 2'd1,
      CSR_CLICK_TICKS      = 2'd2
   } csr_index_type;

   localparam logic [CSR_DATA_WIDTH-1:0] HOLD_INTERVAL_RESET    = 16'd100;
   localparam logic [CSR_DATA_WIDTH-1:0] LONG_PRESS_TICKS_RESET = 16'd1000;
   localparam logic [CSR_DATA_WIDTH-1:0] CLICK_TICKS_RESET      = 16'd300;

   // Tick counter width
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Stream widths (fields padded to whole bytes)
   localparam int REQ_TDATA_WIDTH = 8;
   localparam int RSP_TDATA_WIDTH = 8;
   localparam int EVENT_WIDTH     = 3;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [EVENT_WIDTH-1:0] {
      EV_KEY_DOWN   = 3'd0,
      EV_KEY_UP     = 3'd1,
      EV_CLICK      = 3'd2,
      EV_LONG_PRESS = 3'd3,
      EV_HELD_DOWN  = 3'd4
   } event_kind_type;

   // Events caused by one tick; second is valid only when two is set
   typedef struct packed {
      logic           two;
      event_kind_type first;
      event_kind_type second;
   } entry_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: tick tracker and event classifier
// Holds the press state, counters and registers; turns each tick into an
// entry of zero, one or two events for the queue.
// ----------------------------------------------------------------------------
module bpc_front
   import bpc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tick_valid,
   input  logic                       pad_level,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output logic                       push,
   output entry_type                  push_entry
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > CSR_DATA_WIDTH) ? COUNT_WIDTH : CSR_DATA_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [CSR_DATA_WIDTH-1:0] hold_interval_ff, hold_interval_in;
   logic [CSR_DATA_WIDTH-1:0] long_press_ticks_ff, long_press_ticks_in;
   logic [CSR_DATA_WIDTH-1:0] click_ticks_ff, click_ticks_in;

   logic                   pressed_ff, pressed_in;
   logic [COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_WIDTH-1:0] interval_ff, interval_in;
   logic                   long_reported_ff, long_reported_in;

   logic [COUNT_WIDTH-1:0] elapsed_inc;
   logic [COUNT_WIDTH-1:0] interval_inc;
   logic [CMP_WIDTH-1:0]   elapsed_cmp;
   logic                   interval_hit;
   logic                   is_long;
   logic                   is_held;
   logic                   is_click;

   // Register writes
   always_comb begin
      hold_interval_in    = hold_interval_ff;
      long_press_ticks_in = long_press_ticks_ff;
      click_ticks_in      = click_ticks_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_HOLD_INTERVAL:    hold_interval_in    = csr_wdata;
            CSR_LONG_PRESS_TICKS: long_press_ticks_in = csr_wdata;
            CSR_CLICK_TICKS:      click_ticks_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   // Saturating counters and threshold compares
   assign elapsed_inc  = (elapsed_ff == COUNT_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign interval_inc = (interval_ff == COUNT_MAX) ? interval_ff : interval_ff + 1'b1;
   assign elapsed_cmp  = CMP_WIDTH'(elapsed_inc);
   assign interval_hit = CMP_WIDTH'(interval_inc) >= CMP_WIDTH'(hold_interval_ff);
   assign is_long  = !long_reported_ff && (elapsed_cmp > CMP_WIDTH'(long_press_ticks_ff));
   assign is_held  = elapsed_cmp > CMP_WIDTH'(click_ticks_ff);
   assign is_click = elapsed_cmp < CMP_WIDTH'(click_ticks_ff);

   // Classify the tick and compute next state
   always_comb begin
      pressed_in       = pressed_ff;
      elapsed_in       = elapsed_ff;
      interval_in      = interval_ff;
      long_reported_in = long_reported_ff;
      push             = 1'b0;
      push_entry.two    = 1'b0;
      push_entry.first  = EV_KEY_DOWN;
      push_entry.second = EV_CLICK;
      if (tick_valid) begin
         if (!pressed_ff) begin
            // press starts
            if (!pad_level) begin
               pressed_in       = 1'b1;
               elapsed_in       = '0;
               interval_in      = '0;
               long_reported_in = 1'b0;
               push             = 1'b1;
            end
         end else begin
            elapsed_in = elapsed_inc;
            if (pad_level) begin
               // release: key_up, maybe click
               pressed_in       = 1'b0;
               push             = 1'b1;
               push_entry.first = EV_KEY_UP;
               push_entry.two   = is_click;
            end else if (interval_hit) begin
               // hold check
               interval_in = '0;
               if (is_long) begin
                  long_reported_in  = 1'b1;
                  push              = 1'b1;
                  push_entry.first  = EV_LONG_PRESS;
                  push_entry.second = EV_HELD_DOWN;
                  push_entry.two    = is_held;
               end else if (is_held) begin
                  push             = 1'b1;
                  push_entry.first = EV_HELD_DOWN;
               end
            end else begin
               interval_in = interval_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_interval_ff    <= HOLD_INTERVAL_RESET;
         long_press_ticks_ff <= LONG_PRESS_TICKS_RESET;
         click_ticks_ff      <= CLICK_TICKS_RESET;
         pressed_ff          <= 1'b0;
         elapsed_ff          <= '0;
         interval_ff         <= '0;
         long_reported_ff    <= 1'b0;
      end else begin
         hold_interval_ff    <= hold_interval_in;
         long_press_ticks_ff <= long_press_ticks_in;
         click_ticks_ff      <= click_ticks_in;
         pressed_ff          <= pressed_in;
         elapsed_ff          <= elapsed_in;
         interval_ff         <= interval_in;
         long_reported_ff    <= long_reported_in;
      end
   end

endmodule

// File: rtl/bpc_queue.sv
// ----------------------------------------------------------------------------
// bpc_queue: short FIFO between classifier and event sender
// Holds event entries so the front keeps taking ticks while the back stalls.
// ----------------------------------------------------------------------------
module bpc_queue
   import bpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type status
);

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(QUEUE_DEPTH);

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = entries_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back: event sender
// Unpacks each queue entry into one or two beats on the result stream and
// marks the last beat of each tick.
// ----------------------------------------------------------------------------
module bpc_back
   import bpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head_entry,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output event_kind_type   rsp_kind,
   output logic             rsp_tlast
);

   logic           valid_ff, valid_in;
   event_kind_type kind_ff, kind_in;
   logic           last_ff, last_in;
   logic           pending_ff, pending_in;
   event_kind_type second_ff, second_in;
   logic           load;

   // Output register free when empty or taken this cycle
   assign load = !valid_ff || rsp_tready;
   assign pop  = load && !pending_ff && !status.empty;

   always_comb begin
      valid_in   = valid_ff;
      kind_in    = kind_ff;
      last_in    = last_ff;
      pending_in = pending_ff;
      second_in  = second_ff;
      if (load) begin
         if (pending_ff) begin
            // second event of the tick
            valid_in   = 1'b1;
            kind_in    = second_ff;
            last_in    = 1'b1;
            pending_in = 1'b0;
         end else if (!status.empty) begin
            valid_in   = 1'b1;
            kind_in    = head_entry.first;
            last_in    = !head_entry.two;
            pending_in = head_entry.two;
            second_in  = head_entry.second;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
      end
      kind_ff   <= kind_in;
      last_ff   <= last_in;
      second_ff <= second_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: rtl/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier: click and long-press detector for a button pad
//
// Input stream (req_): one beat per time tick carrying the sampled pad level
// (0 pressed, 1 released) in req_tdata[0]. Result stream (rsp_): one beat per
// event, event code in rsp_tdata[2:0], rsp_tlast set on the last event of the
// tick. Codes: key_down, key_up, click, long_press, held_down.
// Registers on csr_: hold interval, long press threshold, click threshold,
// written while no tick is in flight.
//
// Latency: the first event of a tick reaches rsp_tvalid through the queue
// entry register and then the sender's output register. Throughput: a tick
// per cycle while ticks give at most one event and rsp_tready stays high;
// a tick's two events leave in turn via the sender's single output register.
// A two-entry queue sits between classifier and sender; when the receiver
// stalls, the queue fills and req_tready drops until an entry drains.
// Reset loads the register defaults, clears the press state and empties
// the queue; rsp_tvalid is low after reset.
// ----------------------------------------------------------------------------
module button_press_classifier
   import bpc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // tick stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,   // [0] pad_level, rest zero
   // event stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,   // [2:0] event_kind, rest zero
   output logic                       rsp_tlast,   // last_of_run
   // register writes
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic             push;
   entry_type        push_entry;
   logic             pop;
   entry_type        head_entry;
   queue_status_type status;
   event_kind_type   rsp_kind;

   assign req_tready = !status.full;

   bpc_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .tick_valid (req_tvalid && req_tready),
      .pad_level  (req_tdata[0]),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_entry (push_entry)
   );

   bpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (status)
   );

   bpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_kind),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_TDATA_WIDTH-EVENT_WIDTH){1'b0}}, rsp_kind};

endmodule

// File: rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker: port-level checks for the button press classifier
// Watches the result stream and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module bpc_checker
   import bpc_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic                       rsp_tlast
);

   // Reset leaves no event on the result port
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled beat stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat dropped or changed under stall");

   // key_down, click and held_down always end their tick
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[EVENT_WIDTH-1:0] == EV_KEY_DOWN ||
                     rsp_tdata[EVENT_WIDTH-1:0] == EV_CLICK ||
                     rsp_tdata[EVENT_WIDTH-1:0] == EV_HELD_DOWN) |-> rsp_tlast)
      else $error("event must be last of its tick");

   // A beat that is not last is followed by the tick's closing event
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second event of tick not presented next");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/sv/button_press_classifier_test.sv
// ----------------------------------------------------------------------------
// button_press_classifier_test: self-checking bench for the button classifier
// Feeds pad-level ticks as press/release sequences, predicts key_down, key_up,
// click, long_press and held_down events per tick and checks every event beat
// in order. Sweeps several threshold settings, including zero and all-ones
// values. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module button_press_classifier_test;
   import bpc_pkg::*;

   localparam int STALL_LIMIT = 400;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [CSR_DATA_WIDTH-1:0]  COUNT_MAX = '1;

   typedef struct {
      event_kind_type kind;
      logic           last;
   } event_beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;   // [0] pad_level, rest zero
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;        // [2:0] event_kind, rest zero
   logic                       rsp_tlast;
   logic                       csr_wen = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // pending stimulus and predicted events
   bit             pad_samples[$];
   event_beat_type pending_events[$];

   // predictor copy of registers and press state
   logic [CSR_DATA_WIDTH-1:0] hold_ticks  = HOLD_INTERVAL_RESET;
   logic [CSR_DATA_WIDTH-1:0] long_limit  = LONG_PRESS_TICKS_RESET;
   logic [CSR_DATA_WIDTH-1:0] click_limit = CLICK_TICKS_RESET;
   logic                      is_pressed = 1'b0;
   logic [CSR_DATA_WIDTH-1:0] press_age = '0;
   logic [CSR_DATA_WIDTH-1:0] interval_age = '0;
   logic                      long_sent = 1'b0;

   // idling control: one idle burst per N beats on average, 0 means none
   int req_idle_odds = 0;
   int rsp_idle_odds = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   button_press_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic flag_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // one tick through the classifier, queueing the events it causes
   task automatic classify_tick(logic pad_level);
      event_kind_type kinds[2];
      int n;
      event_beat_type beat;
      n = 0;
      if (!is_pressed) begin
         if (!pad_level) begin
            is_pressed = 1'b1;
            press_age = '0;
            interval_age = '0;
            long_sent = 1'b0;
            kinds[n] = EV_KEY_DOWN;
            n = n + 1;
         end
      end else begin
         if (press_age != COUNT_MAX) press_age = press_age + 1'b1;
         if (pad_level) begin
            is_pressed = 1'b0;
            kinds[n] = EV_KEY_UP;
            n = n + 1;
            if (press_age < click_limit) begin
               kinds[n] = EV_CLICK;
               n = n + 1;
            end
         end else begin
            if (interval_age != COUNT_MAX) interval_age = interval_age + 1'b1;
            // a zero interval acts like one tick
            if (interval_age >= hold_ticks) begin
               interval_age = '0;
               if (!long_sent && press_age > long_limit) begin
                  long_sent = 1'b1;
                  kinds[n] = EV_LONG_PRESS;
                  n = n + 1;
               end
               if (press_age > click_limit) begin
                  kinds[n] = EV_HELD_DOWN;
                  n = n + 1;
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         beat.kind = kinds[i];
         beat.last = (i == n - 1);
         pending_events.push_back(beat);
      end
   endtask

   // tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) classify_tick(req_tdata[0]);
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pad_samples.size() != 0 && req_idle_odds != 0 &&
                         $urandom_range(1, req_idle_odds) == 1) begin
               req_gap <= $urandom_range(0, 10);
               req_tvalid <= 1'b0;
            end else if (pad_samples.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= REQ_TDATA_WIDTH'(pad_samples.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // event receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_gap != 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_odds != 0 && $urandom_range(1, rsp_idle_odds) == 1) begin
         rsp_gap <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // event monitor and stall watchdog
   always @(posedge clock) begin
      event_beat_type beat;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               flag_mismatch("event beat with none predicted", rsp_tdata, -1);
            end else begin
               beat = pending_events.pop_front();
               if (rsp_tdata[EVENT_WIDTH-1:0] !== beat.kind)
                  flag_mismatch("event_kind", rsp_tdata[EVENT_WIDTH-1:0], beat.kind);
               if (rsp_tlast !== beat.last)
                  flag_mismatch("last_of_run", rsp_tlast, beat.last);
               if (rsp_tdata[RSP_TDATA_WIDTH-1:EVENT_WIDTH] !== '0)
                  flag_mismatch("tdata padding", rsp_tdata[RSP_TDATA_WIDTH-1:EVENT_WIDTH], 0);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (pad_samples.size() == 0 && !req_tvalid && pending_events.size() == 0))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("button_press_classifier_test: errors");
            $finish;
         end
      end
   end

   // wait until every tick is taken and every event seen, then let the pipe drain
   task automatic wait_idle();
      @(negedge clock);
      while (reset || pad_samples.size() != 0 || req_tvalid || pending_events.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_HOLD_INTERVAL:    hold_ticks = value;
         CSR_LONG_PRESS_TICKS: long_limit = value;
         CSR_CLICK_TICKS:      click_limit = value;
         default: ;
      endcase
   endtask

   task automatic start_phase(int hold, int long_at, int click_at, int req_odds, int rsp_odds);
      wait_idle();
      write_register(CSR_HOLD_INTERVAL, CSR_DATA_WIDTH'(hold));
      write_register(CSR_LONG_PRESS_TICKS, CSR_DATA_WIDTH'(long_at));
      write_register(CSR_CLICK_TICKS, CSR_DATA_WIDTH'(click_at));
      @(posedge clock);
      csr_wen <= 1'b0;
      req_idle_odds = req_odds;
      rsp_idle_odds = rsp_odds;
      @(negedge clock);
   endtask

   // press of given length: key_down tick, extra held ticks, release tick
   task automatic queue_press(int held);
      pad_samples.push_back(1'b0);
      repeat (held) pad_samples.push_back(1'b0);
      pad_samples.push_back(1'b1);
   endtask

   // mostly well-formed presses around the thresholds, some raw noise
   task automatic queue_random_presses(int beats);
      int pushed, r, k, span;
      pushed = 0;
      while (pushed < beats) begin
         r = $urandom_range(0, 9);
         if (r < 2) begin
            k = $urandom_range(1, 6);
            repeat (k) pad_samples.push_back(1'($urandom_range(0, 1)));
            pushed += k;
         end else begin
            k = $urandom_range(0, 3);
            repeat (k) pad_samples.push_back(1'b1);
            pushed += k;
            if (r == 2 && click_limit < 60) begin
               k = int'(click_limit) + int'($urandom_range(0, 2)) - 1;
               if (k < 0) k = 0;
            end else begin
               span = (long_limit > click_limit) ? int'(long_limit) : int'(click_limit);
               span = span + 2 * int'(hold_ticks) + 4;
               if (span > 70) span = 70;
               k = $urandom_range(0, span);
            end
            queue_press(k);
            pushed += k + 2;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: idle tick, short presses give click
      wait_idle();
      req_idle_odds = 3;
      rsp_idle_odds = 3;
      pad_samples.push_back(1'b1);
      queue_press(1);
      queue_press(0);

      // tiny thresholds: held_down alone, long_press with held_down in one tick,
      // release at and above the click threshold
      start_phase(1, 3, 2, 4, 4);
      queue_press(7);
      queue_press(1);
      queue_press(2);
      pad_samples.push_back(1'b1);

      start_phase(1, 0, 0, 6, 3);
      queue_random_presses(110);
      start_phase(0, 5, 3, 0, 0);
      queue_random_presses(110);

      // write to an unused index must leave the thresholds alone
      start_phase(3, 12, 6, 12, 5);
      write_register(CSR_UNUSED_INDEX, CSR_DATA_WIDTH'($urandom_range(0, 65535)));
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
      queue_random_presses(110);

      start_phase(65535, 65535, 65535, 4, 8);
      queue_random_presses(110);
      start_phase($urandom_range(1, 6), $urandom_range(0, 40), $urandom_range(0, 30), 5, 5);
      queue_random_presses(110);
      start_phase(2, 20, 40, 0, 6);
      queue_random_presses(110);
      start_phase($urandom_range(0, 6), $urandom_range(0, 40), $urandom_range(0, 30), 8, 0);
      queue_random_presses(110);

      // closing stretch without idling
      start_phase($urandom_range(1, 5), $urandom_range(0, 30), $urandom_range(0, 20), 0, 0);
      queue_random_presses(110);

      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("button_press_classifier_test: clean");
      else
         $display("button_press_classifier_test: errors");
      $finish;
   end

endmodule
